[src/sqb_pkg.sv]
// shared constants, types and corner tables for the sprite quad batcher
`default_nettype none
package sqb_pkg;

	localparam int MAX_VERTS   = 4096;
	localparam int NUM_SLOTS   = 16;
	localparam int HANDLE_BITS = 16;

	localparam int COORD_W = 32;
	localparam int TEX_W   = 16;
	localparam int SLOT_W  = 4;
	localparam int BV_W    = 13;
	localparam int BS_W    = 5;

	localparam int QUAD_VERTS = 6;
	localparam int VCNT_W     = $clog2(MAX_VERTS + 1);
	localparam int VCHK_W     = VCNT_W + 1;
	localparam int SCNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int SIDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int KEY_W      = (HANDLE_BITS < TEX_W) ? HANDLE_BITS : TEX_W;

	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_FLUSH = 3'd0;
	localparam logic [STEP_W-1:0] STEP_V0    = 3'd1;
	localparam logic [STEP_W-1:0] STEP_LAST  = 3'd6;

	localparam logic CMD_DRAW    = 1'b0;
	localparam logic CMD_EOF     = 1'b1;
	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_FLUSH  = 1'b1;

	typedef struct packed {
		logic                       do_flush;
		logic                       do_quad;
		logic [BV_W-1:0]            flush_verts;
		logic [BS_W-1:0]            flush_slots;
		logic [SLOT_W-1:0]          slot_index;
		logic [TEX_W-1:0]           slot_texture;
		logic signed [COORD_W-1:0]  xaxis_x;
		logic signed [COORD_W-1:0]  xaxis_y;
		logic signed [COORD_W-1:0]  xaxis_z;
		logic signed [COORD_W-1:0]  yaxis_x;
		logic signed [COORD_W-1:0]  yaxis_y;
		logic signed [COORD_W-1:0]  yaxis_z;
		logic signed [COORD_W-1:0]  origin_x;
		logic signed [COORD_W-1:0]  origin_y;
		logic signed [COORD_W-1:0]  origin_z;
	} quad_desc_t;

	typedef struct packed {
		logic                       kind;
		logic signed [COORD_W-1:0]  pos_x;
		logic signed [COORD_W-1:0]  pos_y;
		logic signed [COORD_W-1:0]  pos_z;
		logic                       tex_u;
		logic                       tex_v;
		logic [SLOT_W-1:0]          slot_index;
		logic [TEX_W-1:0]           slot_texture;
		logic [BV_W-1:0]            batch_vertices;
		logic [BS_W-1:0]            batch_slots;
		logic                       last;
	} res_t;

	// corner order 0,1,2,2,3,0 as {u, v} per vertex step
	function automatic logic [1:0] step_uv(input logic [STEP_W-1:0] s);
		logic [1:0] uv;
		unique case (s)
			3'd1: uv = 2'b00;
			3'd2: uv = 2'b10;
			3'd3: uv = 2'b11;
			3'd4: uv = 2'b11;
			3'd5: uv = 2'b01;
			3'd6: uv = 2'b00;
			default: uv = 2'b00;
		endcase
		return uv;
	endfunction

endpackage
`default_nettype wire

[src/sprite_quad_batcher_unit.sv]
// top level of the sprite quad batcher
// A draw item yields six vertex items, or seven when a batch flush item comes
// first (vertex budget or texture slot table exhausted); an end-of-frame item
// yields one flush item, or none for an empty batch. The back end sequencer
// sends one item per cycle while a descriptor waits and the output is not stalled.
// The front end takes one item per cycle while its two-entry descriptor queue
// has room. The output register holds each result until it is taken, and the
// back end waits while a result is stalled. There is no startup sweep after reset.
`default_nettype none
module sprite_quad_batcher_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               cmd,
	input  wire logic signed [sqb_pkg::COORD_W-1:0] xaxis_x,
	input  wire logic signed [sqb_pkg::COORD_W-1:0] xaxis_y,
	input  wire logic signed [sqb_pkg::COORD_W-1:0] xaxis_z,
	input  wire logic signed [sqb_pkg::COORD_W-1:0] yaxis_x,
	input  wire logic signed [sqb_pkg::COORD_W-1:0] yaxis_y,
	input  wire logic signed [sqb_pkg::COORD_W-1:0] yaxis_z,
	input  wire logic signed [sqb_pkg::COORD_W-1:0] origin_x,
	input  wire logic signed [sqb_pkg::COORD_W-1:0] origin_y,
	input  wire logic signed [sqb_pkg::COORD_W-1:0] origin_z,
	input  wire logic [sqb_pkg::TEX_W-1:0]          texture_handle,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    kind,
	output logic signed [sqb_pkg::COORD_W-1:0]      pos_x,
	output logic signed [sqb_pkg::COORD_W-1:0]      pos_y,
	output logic signed [sqb_pkg::COORD_W-1:0]      pos_z,
	output logic                                    tex_u,
	output logic                                    tex_v,
	output logic [sqb_pkg::SLOT_W-1:0]              slot_index,
	output logic [sqb_pkg::TEX_W-1:0]               slot_texture,
	output logic [sqb_pkg::BV_W-1:0]                batch_vertices,
	output logic [sqb_pkg::BS_W-1:0]                batch_slots,
	output logic                                    last
);

	logic                push;
	sqb_pkg::quad_desc_t push_data;
	logic                q_full;
	logic                pop;
	sqb_pkg::quad_desc_t head;
	logic                q_empty;
	sqb_pkg::res_t       res;

	sqb_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.xaxis_x        (xaxis_x),
		.xaxis_y        (xaxis_y),
		.xaxis_z        (xaxis_z),
		.yaxis_x        (yaxis_x),
		.yaxis_y        (yaxis_y),
		.yaxis_z        (yaxis_z),
		.origin_x       (origin_x),
		.origin_y       (origin_y),
		.origin_z       (origin_z),
		.texture_handle (texture_handle),
		.push           (push),
		.push_data      (push_data),
		.q_full         (q_full)
	);

	sqb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (head),
		.empty     (q_empty)
	);

	sqb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (q_empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.res        (res)
	);

	assign kind           = res.kind;
	assign pos_x          = res.pos_x;
	assign pos_y          = res.pos_y;
	assign pos_z          = res.pos_z;
	assign tex_u          = res.tex_u;
	assign tex_v          = res.tex_v;
	assign slot_index     = res.slot_index;
	assign slot_texture   = res.slot_texture;
	assign batch_vertices = res.batch_vertices;
	assign batch_slots    = res.batch_slots;
	assign last           = res.last;

endmodule
`default_nettype wire

[src/sqb_front.sv]
// front end: accepts commands, tracks batch counts and slot table, builds work descriptors
`default_nettype none
module sqb_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               cmd,
	input  wire logic signed [sqb_pkg::COORD_W-1:0] xaxis_x,
	input  wire logic signed [sqb_pkg::COORD_W-1:0] xaxis_y,
	input  wire logic signed [sqb_pkg::COORD_W-1:0] xaxis_z,
	input  wire logic signed [sqb_pkg::COORD_W-1:0] yaxis_x,
	input  wire logic signed [sqb_pkg::COORD_W-1:0] yaxis_y,
	input  wire logic signed [sqb_pkg::COORD_W-1:0] yaxis_z,
	input  wire logic signed [sqb_pkg::COORD_W-1:0] origin_x,
	input  wire logic signed [sqb_pkg::COORD_W-1:0] origin_y,
	input  wire logic signed [sqb_pkg::COORD_W-1:0] origin_z,
	input  wire logic [sqb_pkg::TEX_W-1:0]          texture_handle,
	output logic                                    push,
	output sqb_pkg::quad_desc_t                     push_data,
	input  wire logic                               q_full
);

	logic [sqb_pkg::VCNT_W-1:0] vcount_q;
	logic [sqb_pkg::SCNT_W-1:0] slots_q;
	logic [sqb_pkg::KEY_W-1:0]  table_q [sqb_pkg::NUM_SLOTS];

	logic                        accept;
	logic [sqb_pkg::KEY_W-1:0]   key;
	logic [sqb_pkg::NUM_SLOTS-1:0] hit;
	logic [sqb_pkg::SIDX_W-1:0]  hit_idx;
	logic                        vc_over;
	logic                        found;
	logic                        slot_full;
	logic                        do_flush;
	logic [sqb_pkg::SCNT_W-1:0]  base_slots;
	logic [sqb_pkg::SIDX_W-1:0]  slot_sel;
	logic [sqb_pkg::VCNT_W-1:0]  vcount_d;
	logic [sqb_pkg::SCNT_W-1:0]  slots_d;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign key      = texture_handle[sqb_pkg::KEY_W-1:0];

	always_comb begin
		hit     = '0;
		hit_idx = '0;
		for (int i = 0; i < sqb_pkg::NUM_SLOTS; i++) begin
			hit[i] = (sqb_pkg::SCNT_W'(i) < slots_q) && (table_q[i] == key);
		end
		for (int i = sqb_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (hit[i]) begin
				hit_idx = sqb_pkg::SIDX_W'(i);
			end
		end
	end

	always_comb begin
		vc_over    = (sqb_pkg::VCHK_W'(vcount_q) + sqb_pkg::VCHK_W'(sqb_pkg::QUAD_VERTS))
		             > sqb_pkg::VCHK_W'(sqb_pkg::MAX_VERTS);
		found      = (|hit) && !vc_over;
		slot_full  = !found && !vc_over && (slots_q >= sqb_pkg::SCNT_W'(sqb_pkg::NUM_SLOTS));
		base_slots = (vc_over || slot_full) ? '0 : slots_q;
		slot_sel   = found ? hit_idx : base_slots[sqb_pkg::SIDX_W-1:0];
		if (cmd == sqb_pkg::CMD_EOF) begin
			do_flush = (vcount_q != '0);
			vcount_d = '0;
			slots_d  = '0;
		end else begin
			do_flush = vc_over || slot_full;
			vcount_d = (do_flush ? '0 : vcount_q) + sqb_pkg::VCNT_W'(sqb_pkg::QUAD_VERTS);
			slots_d  = base_slots + sqb_pkg::SCNT_W'(!found);
		end
	end

	assign push = accept && ((cmd == sqb_pkg::CMD_DRAW) || (vcount_q != '0));

	always_comb begin
		push_data              = '0;
		push_data.do_flush     = do_flush;
		push_data.do_quad      = (cmd == sqb_pkg::CMD_DRAW);
		push_data.flush_verts  = sqb_pkg::BV_W'(vcount_q);
		push_data.flush_slots  = sqb_pkg::BS_W'(slots_q);
		push_data.slot_index   = sqb_pkg::SLOT_W'(slot_sel);
		push_data.slot_texture = sqb_pkg::TEX_W'(key);
		push_data.xaxis_x      = xaxis_x;
		push_data.xaxis_y      = xaxis_y;
		push_data.xaxis_z      = xaxis_z;
		push_data.yaxis_x      = yaxis_x;
		push_data.yaxis_y      = yaxis_y;
		push_data.yaxis_z      = yaxis_z;
		push_data.origin_x     = origin_x;
		push_data.origin_y     = origin_y;
		push_data.origin_z     = origin_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			slots_q  <= '0;
		end else if (accept) begin
			vcount_q <= vcount_d;
			slots_q  <= slots_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (cmd == sqb_pkg::CMD_DRAW) && !found) begin
			table_q[slot_sel] <= key;
		end
	end

	a_vcount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcount_q <= sqb_pkg::VCNT_W'(sqb_pkg::MAX_VERTS))
		else $error("vertex count above budget");

	a_slots_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slots_q <= sqb_pkg::SCNT_W'(sqb_pkg::NUM_SLOTS))
		else $error("slot count above table size");

	a_draw_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == sqb_pkg::CMD_DRAW) |=> (vcount_q != '0 && slots_q != '0))
		else $error("draw left an empty batch");

endmodule
`default_nettype wire

[src/sqb_queue.sv]
// short descriptor queue between front and back
`default_nettype none
module sqb_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire sqb_pkg::quad_desc_t push_data,
	output logic                     full,
	input  wire logic                pop,
	output sqb_pkg::quad_desc_t      pop_data,
	output logic                     empty
);

	sqb_pkg::quad_desc_t          mem_q [sqb_pkg::Q_DEPTH];
	logic [sqb_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [sqb_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [sqb_pkg::QCNT_W-1:0]   count_q;
	logic                         do_push;
	logic                         do_pop;

	assign full     = (count_q == sqb_pkg::QCNT_W'(sqb_pkg::Q_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	function automatic logic [sqb_pkg::QPTR_W-1:0] ptr_inc(input logic [sqb_pkg::QPTR_W-1:0] p);
		return (p == sqb_pkg::QPTR_W'(sqb_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sqb_pkg::QCNT_W'(sqb_pkg::Q_DEPTH))
		else $error("queue count above depth");

endmodule
`default_nettype wire

[src/sqb_back.sv]
// back end: emits flush and/or six vertices per descriptor into the output register
`default_nettype none
module sqb_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sqb_pkg::quad_desc_t head,
	input  wire logic                head_empty,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output sqb_pkg::res_t            res
);

	logic [sqb_pkg::STEP_W-1:0] step_q;
	logic [sqb_pkg::STEP_W-1:0] cur;
	logic                       is_last;
	logic                       load;
	logic [1:0]                 uv;
	logic                       out_valid_q;
	sqb_pkg::res_t              res_q;
	sqb_pkg::res_t              res_d;

	function automatic logic signed [sqb_pkg::COORD_W:0] half_term(
		input logic signed [sqb_pkg::COORD_W-1:0] a,
		input logic                               positive
	);
		logic signed [sqb_pkg::COORD_W:0] t;
		t = positive ? {a[sqb_pkg::COORD_W-1], a} : -{a[sqb_pkg::COORD_W-1], a};
		return t >>> 1;
	endfunction

	function automatic logic signed [sqb_pkg::COORD_W-1:0] vert_coord(
		input logic signed [sqb_pkg::COORD_W-1:0] o,
		input logic signed [sqb_pkg::COORD_W-1:0] ax,
		input logic signed [sqb_pkg::COORD_W-1:0] ay,
		input logic                               xp,
		input logic                               yp
	);
		logic signed [sqb_pkg::COORD_W+1:0] sum;
		logic signed [sqb_pkg::COORD_W-1:0] r;
		sum = {{2{o[sqb_pkg::COORD_W-1]}}, o}
		    + (sqb_pkg::COORD_W+2)'(half_term(ax, xp))
		    + (sqb_pkg::COORD_W+2)'(half_term(ay, yp));
		if (sum[sqb_pkg::COORD_W+1:sqb_pkg::COORD_W-1] == 3'b000
		    || sum[sqb_pkg::COORD_W+1:sqb_pkg::COORD_W-1] == 3'b111) begin
			r = sum[sqb_pkg::COORD_W-1:0];
		end else if (!sum[sqb_pkg::COORD_W+1]) begin
			r = {1'b0, {(sqb_pkg::COORD_W-1){1'b1}}};
		end else begin
			r = {1'b1, {(sqb_pkg::COORD_W-1){1'b0}}};
		end
		return r;
	endfunction

	assign cur     = (step_q == sqb_pkg::STEP_FLUSH && !head.do_flush) ? sqb_pkg::STEP_V0 : step_q;
	assign is_last = head.do_quad ? (cur == sqb_pkg::STEP_LAST) : 1'b1;
	assign load    = !head_empty && (!out_valid_q || !out_stall);
	assign pop     = load && is_last;
	assign uv      = sqb_pkg::step_uv(cur);

	always_comb begin
		res_d      = '0;
		res_d.last = is_last;
		if (cur == sqb_pkg::STEP_FLUSH) begin
			res_d.kind           = sqb_pkg::KIND_FLUSH;
			res_d.batch_vertices = head.flush_verts;
			res_d.batch_slots    = head.flush_slots;
		end else begin
			res_d.kind         = sqb_pkg::KIND_VERTEX;
			res_d.pos_x        = vert_coord(head.origin_x, head.xaxis_x, head.yaxis_x, uv[1], uv[0]);
			res_d.pos_y        = vert_coord(head.origin_y, head.xaxis_y, head.yaxis_y, uv[1], uv[0]);
			res_d.pos_z        = vert_coord(head.origin_z, head.xaxis_z, head.yaxis_z, uv[1], uv[0]);
			res_d.tex_u        = uv[1];
			res_d.tex_v        = uv[0];
			res_d.slot_index   = head.slot_index;
			res_d.slot_texture = head.slot_texture;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= sqb_pkg::STEP_FLUSH;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q      <= is_last ? sqb_pkg::STEP_FLUSH : cur + 1'b1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= sqb_pkg::STEP_LAST)
		else $error("vertex step out of range");

	a_flush_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && res.kind == sqb_pkg::KIND_FLUSH) |-> (res.batch_vertices != '0))
		else $error("flush of an empty batch");

	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && res.kind == sqb_pkg::KIND_VERTEX && res.last) |-> (!res.tex_u && !res.tex_v))
		else $error("quad does not close on its first corner");

endmodule
`default_nettype wire

[dv/sprite_quad_batcher_unit_tb.sv]
// testbench for the sprite quad batcher: draw and end-of-frame items checked against a predictor
`timescale 1ns / 1ps
module sprite_quad_batcher_unit_tb;

	localparam longint POS_MAX = 64'sd2147483647;
	localparam longint NEG_MIN = -64'sd2147483648;
	// corner order 0,1,2,2,3,0 unrolled, bit i = vertex i
	localparam logic [5:0] U_SEQ = 6'b001110;
	localparam logic [5:0] V_SEQ = 6'b011100;

	typedef struct packed {
		logic              cmd;
		logic signed [31:0] xx, xy, xz, yx, yy, yz, ox, oy, oz;
		logic [15:0]       tex;
	} sprite_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = sqb_pkg::CMD_DRAW;
	logic signed [sqb_pkg::COORD_W-1:0] xaxis_x = '0, xaxis_y = '0, xaxis_z = '0;
	logic signed [sqb_pkg::COORD_W-1:0] yaxis_x = '0, yaxis_y = '0, yaxis_z = '0;
	logic signed [sqb_pkg::COORD_W-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic [sqb_pkg::TEX_W-1:0] texture_handle = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic kind;
	logic signed [sqb_pkg::COORD_W-1:0] pos_x, pos_y, pos_z;
	logic tex_u, tex_v;
	logic [sqb_pkg::SLOT_W-1:0] slot_index;
	logic [sqb_pkg::TEX_W-1:0] slot_texture;
	logic [sqb_pkg::BV_W-1:0] batch_vertices;
	logic [sqb_pkg::BS_W-1:0] batch_slots;
	logic last;

	sprite_quad_batcher_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd),
		.xaxis_x(xaxis_x), .xaxis_y(xaxis_y), .xaxis_z(xaxis_z),
		.yaxis_x(yaxis_x), .yaxis_y(yaxis_y), .yaxis_z(yaxis_z),
		.origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
		.texture_handle(texture_handle),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.tex_u(tex_u), .tex_v(tex_v),
		.slot_index(slot_index), .slot_texture(slot_texture),
		.batch_vertices(batch_vertices), .batch_slots(batch_slots),
		.last(last)
	);

	always #1 clk = ~clk;

	sprite_req_t requests[$];
	sqb_pkg::res_t batch_stream[$];
	int reqs_total = 0;
	int reqs_accepted = 0;
	int errors = 0;

	// batch state as the block should hold it
	int vcount = 0;
	int slots_in_use = 0;
	logic [sqb_pkg::TEX_W-1:0] bound_tex [0:sqb_pkg::NUM_SLOTS-1];
	sqb_pkg::res_t step_out [0:6];
	int step_n;

	task automatic add_req(input sprite_req_t r);
		requests.insert(requests.size(), r);
	endtask

	function automatic logic signed [31:0] corner_coord(input logic signed [31:0] org,
			input logic signed [31:0] ax, input logic signed [31:0] ay,
			input logic up, input logic vp);
		longint tx, ty, s;
		tx = up ? longint'(ax) : -longint'(ax);
		ty = vp ? longint'(ay) : -longint'(ay);
		s = longint'(org) + (tx >>> 1) + (ty >>> 1);
		if (s > POS_MAX)
			s = POS_MAX;
		else if (s < NEG_MIN)
			s = NEG_MIN;
		return s[31:0];
	endfunction

	task automatic close_batch();
		sqb_pkg::res_t rec;
		if (vcount != 0) begin
			rec = '0;
			rec.kind = sqb_pkg::KIND_FLUSH;
			rec.batch_vertices = vcount[sqb_pkg::BV_W-1:0];
			rec.batch_slots = slots_in_use[sqb_pkg::BS_W-1:0];
			step_out[step_n] = rec;
			step_n++;
		end
		vcount = 0;
		slots_in_use = 0;
	endtask

	task automatic batch_request(input sprite_req_t r);
		sqb_pkg::res_t rec;
		int hit;
		step_n = 0;
		if (r.cmd == sqb_pkg::CMD_EOF) begin
			close_batch();
		end else begin
			if (vcount + sqb_pkg::QUAD_VERTS > sqb_pkg::MAX_VERTS)
				close_batch();
			hit = -1;
			for (int i = 0; i < slots_in_use && i < sqb_pkg::NUM_SLOTS; i++)
				if (hit < 0 && bound_tex[i] == r.tex)
					hit = i;
			if (hit < 0) begin
				if (slots_in_use >= sqb_pkg::NUM_SLOTS)
					close_batch();
				hit = slots_in_use;
				bound_tex[hit] = r.tex;
				slots_in_use++;
			end
			for (int s = 0; s < sqb_pkg::QUAD_VERTS; s++) begin
				rec = '0;
				rec.kind = sqb_pkg::KIND_VERTEX;
				rec.pos_x = corner_coord(r.ox, r.xx, r.yx, U_SEQ[s], V_SEQ[s]);
				rec.pos_y = corner_coord(r.oy, r.xy, r.yy, U_SEQ[s], V_SEQ[s]);
				rec.pos_z = corner_coord(r.oz, r.xz, r.yz, U_SEQ[s], V_SEQ[s]);
				rec.tex_u = U_SEQ[s];
				rec.tex_v = V_SEQ[s];
				rec.slot_index = hit[sqb_pkg::SLOT_W-1:0];
				rec.slot_texture = bound_tex[hit];
				step_out[step_n] = rec;
				step_n++;
			end
			vcount += sqb_pkg::QUAD_VERTS;
		end
		if (step_n > 0) begin
			rec = step_out[step_n-1];
			rec.last = 1'b1;
			step_out[step_n-1] = rec;
		end
		for (int i = 0; i < step_n; i++)
			batch_stream.insert(batch_stream.size(), step_out[i]);
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return 32'sd0;
			3: return ($urandom_range(0, 1) != 0) ? 32'sd1 : -32'sd1;
			4, 5: return $signed($urandom_range(0, 2097152)) - 32'sd1048576;
			default: return $urandom();
		endcase
	endfunction

	function automatic sprite_req_t rand_req(input logic c, input logic [15:0] tex);
		sprite_req_t r;
		r.cmd = c;
		r.xx = rand_coord(); r.xy = rand_coord(); r.xz = rand_coord();
		r.yx = rand_coord(); r.yy = rand_coord(); r.yz = rand_coord();
		r.ox = rand_coord(); r.oy = rand_coord(); r.oz = rand_coord();
		r.tex = tex;
		return r;
	endfunction

	function automatic sprite_req_t uniform_draw(input logic signed [31:0] org,
			input logic signed [31:0] axis, input logic [15:0] tex);
		sprite_req_t r;
		r.cmd = sqb_pkg::CMD_DRAW;
		r.xx = axis; r.xy = axis; r.xz = axis;
		r.yx = axis; r.yy = axis; r.yz = axis;
		r.ox = org; r.oy = org; r.oz = org;
		r.tex = tex;
		return r;
	endfunction

	function automatic int idle_len();
		if ($urandom_range(0, 99) < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// stimulus
	logic [15:0] pool [0:23];
	int pool_n, frame_len, rand_count;
	sprite_req_t r;

	initial begin
		add_req(rand_req(sqb_pkg::CMD_EOF, 16'($urandom())));
		add_req(uniform_draw(32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'hFFFF));
		add_req(uniform_draw(32'sh80000000, 32'sh80000000, 16'h0000));
		add_req(uniform_draw(32'sh7FFFFFFF, 32'sh80000000, 16'hFFFF));
		add_req(uniform_draw(32'sh80000000, 32'sh7FFFFFFF, 16'h0000));
		// odd axis values exercise floor rounding of the half terms
		r = uniform_draw(32'sd0, 32'sd0, 16'hFFFF);
		r.xx = 32'sd1; r.xy = -32'sd1; r.xz = 32'sd3;
		r.yx = -32'sd3; r.yy = 32'sd5; r.yz = -32'sd7;
		add_req(r);
		// fill the slot table, then overflow it
		for (int i = 1; i <= 14; i++)
			add_req(rand_req(sqb_pkg::CMD_DRAW, 16'(i)));
		add_req(rand_req(sqb_pkg::CMD_DRAW, 16'hA5A5));
		add_req(rand_req(sqb_pkg::CMD_EOF, 16'($urandom())));
		add_req(rand_req(sqb_pkg::CMD_EOF, 16'($urandom())));

		rand_count = 0;
		while (rand_count < 375) begin
			pool_n = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 4);
			for (int i = 0; i < pool_n; i++)
				pool[i] = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 7)) : 16'($urandom());
			frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			for (int i = 0; i < frame_len; i++) begin
				if ($urandom_range(0, 19) == 0) begin
					add_req(rand_req(sqb_pkg::CMD_EOF, 16'($urandom())));
					rand_count++;
				end
				add_req(rand_req(sqb_pkg::CMD_DRAW, pool[$urandom_range(0, pool_n - 1)]));
				rand_count++;
			end
			if ($urandom_range(0, 7) != 0) begin
				add_req(rand_req(sqb_pkg::CMD_EOF, 16'($urandom())));
				rand_count++;
			end
		end
		add_req(rand_req(sqb_pkg::CMD_EOF, 16'($urandom())));
		reqs_total = requests.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (reqs_accepted < reqs_total)
			@(posedge clk);
		while (batch_stream.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (batch_stream.size() != 0)
			$display("%0t: %0d expected items never arrived", $time, batch_stream.size());
		if (errors == 0 && batch_stream.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	// driver
	sprite_req_t cur;
	int gap_in = 0;
	logic calm_in = 1'b0;
	int calm_in_cnt = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (calm_in_cnt == 0) begin
				calm_in = ($urandom_range(0, 2) == 0);
				calm_in_cnt = $urandom_range(100, 300);
			end else begin
				calm_in_cnt--;
			end
			if (in_valid && !in_stall) begin
				batch_request(cur);
				reqs_accepted++;
			end
			if (!(in_valid && in_stall)) begin
				if (gap_in > 0) begin
					gap_in--;
					in_valid <= 1'b0;
				end else if (requests.size() != 0) begin
					cur = requests.pop_front();
					cmd <= cur.cmd;
					xaxis_x <= cur.xx; xaxis_y <= cur.xy; xaxis_z <= cur.xz;
					yaxis_x <= cur.yx; yaxis_y <= cur.yy; yaxis_z <= cur.yz;
					origin_x <= cur.ox; origin_y <= cur.oy; origin_z <= cur.oz;
					texture_handle <= cur.tex;
					in_valid <= 1'b1;
					gap_in = (calm_in || $urandom_range(0, 99) < 55) ? 0 : idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	sqb_pkg::res_t want;
	int stall_left = 0;
	logic calm_out = 1'b0;
	int calm_out_cnt = 0;

	task automatic check_field(input string what, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, what, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (batch_stream.size() == 0) begin
					errors++;
					$display("%0t: unexpected item, expected none, actual kind %0h",
						$time, kind);
				end else begin
					want = batch_stream.pop_front();
					check_field("kind", want.kind, kind);
					check_field("pos_x", want.pos_x, pos_x);
					check_field("pos_y", want.pos_y, pos_y);
					check_field("pos_z", want.pos_z, pos_z);
					check_field("tex_u", want.tex_u, tex_u);
					check_field("tex_v", want.tex_v, tex_v);
					check_field("slot_index", want.slot_index, slot_index);
					check_field("slot_texture", want.slot_texture, slot_texture);
					check_field("batch_vertices", want.batch_vertices, batch_vertices);
					check_field("batch_slots", want.batch_slots, batch_slots);
					check_field("last", want.last, last);
				end
			end
			if (calm_out_cnt == 0) begin
				calm_out = ($urandom_range(0, 2) == 0);
				calm_out_cnt = $urandom_range(100, 300);
			end else begin
				calm_out_cnt--;
			end
			if (stall_left == 0 && !calm_out && $urandom_range(0, 3) == 0)
				stall_left = idle_len();
			out_stall <= (stall_left != 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

endmodule

[sprite_quad_batcher_unit.f]
src/sqb_pkg.sv
src/sqb_front.sv
src/sqb_queue.sv
src/sqb_back.sv
src/sprite_quad_batcher_unit.sv
dv/sprite_quad_batcher_unit_tb.sv
